// ===== rtl/assert_macros.svh =====
// Assertion helpers for the file that checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk_sig, rst_sig, ante, cons, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/hcrm_pkg.sv =====
package hcrm_pkg;

  localparam int SAMPLE_BITS_DEF = 10;
  localparam int COUNT_BITS_DEF  = 16;
  localparam int TICK_BITS       = 16;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [TICK_BITS-1:0] TIMEOUT_RESET = 16'hFFFF;

  typedef enum logic [1:0] {
    CMD_START  = 2'd0,
    CMD_SAMPLE = 2'd1,
    CMD_TICK   = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_ZERO = 2'd1,
    PH_RISE = 2'd2,
    PH_ACC  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_TO_ZERO = 2'd1,
    ST_TO_RISE = 2'd2,
    ST_TO_HALF = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_DIV  = 2'd1,
    BK_SQRT = 2'd2,
    BK_OUT  = 2'd3
  } back_state_t;

endpackage

// ===== rtl/hcrm_ifs.sv =====
interface hcrm_in_if import hcrm_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [1:0]             command;
  logic [1:0]             channel;
  logic [SAMPLE_BITS-1:0] sample;

  modport source (output valid, command, channel, sample, input ready);
  modport sink   (input valid, command, channel, sample, output ready);
endinterface

interface hcrm_out_if import hcrm_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [1:0]             tag;
  logic [1:0]             status;
  logic [SAMPLE_BITS-1:0] rms;

  modport source (output valid, tag, status, rms, input ready);
  modport sink   (input valid, tag, status, rms, output ready);
endinterface

interface hcrm_cfg_if import hcrm_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [TICK_BITS-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== rtl/hcrm_front.sv =====
module hcrm_front import hcrm_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst,
  hcrm_in_if.sink                                     item,
  input  logic [TICK_BITS-1:0]                        timeout_ticks,
  output logic                                        q_push,
  output logic [4+2*SAMPLE_BITS+2*COUNT_BITS-1:0]     q_data,
  input  logic                                        q_full
);

  localparam int SQ_BITS  = 2 * SAMPLE_BITS;
  localparam int SUM_BITS = SQ_BITS + COUNT_BITS;

  phase_t                phase, phase_next;
  logic [1:0]            held_tag, held_tag_next;
  logic [TICK_BITS-1:0]  tick_count, tick_next;
  logic [SUM_BITS-1:0]   square_sum, sum_next;
  logic [COUNT_BITS-1:0] sample_count, count_next;

  logic                  accept;
  logic [SQ_BITS-1:0]    square;
  logic [SUM_BITS:0]     sum_wide;
  logic [SUM_BITS-1:0]   sum_sat;
  logic [COUNT_BITS-1:0] count_inc;
  logic [TICK_BITS-1:0]  tick_inc;
  status_t               job_status;

  function automatic status_t phase_status(phase_t p);
    status_t s;
    case (p)
      PH_ZERO: s = ST_TO_ZERO;
      PH_RISE: s = ST_TO_RISE;
      PH_ACC:  s = ST_TO_HALF;
      default: s = ST_OK;
    endcase
    return s;
  endfunction

  assign item.ready = !q_full;
  assign accept     = item.valid && item.ready;

  assign square    = SQ_BITS'(item.sample) * SQ_BITS'(item.sample);
  assign sum_wide  = {1'b0, square_sum} + (SUM_BITS+1)'(square);
  assign sum_sat   = sum_wide[SUM_BITS] ? '1 : sum_wide[SUM_BITS-1:0];
  assign count_inc = (sample_count == '1) ? sample_count : sample_count + 1'b1;
  assign tick_inc  = (tick_count == '1) ? tick_count : tick_count + 1'b1;

  always_comb begin
    phase_next    = phase;
    held_tag_next = held_tag;
    tick_next     = tick_count;
    sum_next      = square_sum;
    count_next    = sample_count;
    q_push        = 1'b0;
    job_status    = ST_OK;
    if (accept) begin
      case (item.command)
        CMD_START: begin
          held_tag_next = item.channel;
          phase_next    = PH_ZERO;
          tick_next     = '0;
          sum_next      = '0;
          count_next    = '0;
        end
        CMD_SAMPLE: begin
          case (phase)
            PH_ZERO: begin
              if (item.sample == '0) begin
                phase_next = PH_RISE;
                tick_next  = '0;
              end
            end
            PH_RISE: begin
              if (item.sample != '0) begin
                phase_next = PH_ACC;
                tick_next  = '0;
                sum_next   = SUM_BITS'(square);
                count_next = COUNT_BITS'(1);
              end
            end
            PH_ACC: begin
              sum_next   = sum_sat;
              count_next = count_inc;
              if (item.sample == '0) begin
                q_push     = 1'b1;
                phase_next = PH_IDLE;
              end
            end
            default: begin
            end
          endcase
        end
        CMD_TICK: begin
          if (phase != PH_IDLE) begin
            tick_next = tick_inc;
            if (tick_inc >= timeout_ticks) begin
              q_push     = 1'b1;
              job_status = phase_status(phase);
              phase_next = PH_IDLE;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // A finished half cycle carries its updated totals; a timeout ignores them.
  assign q_data = {held_tag, job_status, sum_sat, count_inc};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      held_tag     <= '0;
      tick_count   <= '0;
      square_sum   <= '0;
      sample_count <= '0;
    end else begin
      phase        <= phase_next;
      held_tag     <= held_tag_next;
      tick_count   <= tick_next;
      square_sum   <= sum_next;
      sample_count <= count_next;
    end
  end

endmodule

// ===== rtl/hcrm_queue.sv =====
module hcrm_queue import hcrm_pkg::*; #(
  parameter int WIDTH = 4 + 2 * SAMPLE_BITS_DEF + 2 * COUNT_BITS_DEF,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]    slots [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [CNT_BITS-1:0] fill;

  assign full     = (fill == CNT_BITS'(DEPTH));
  assign empty    = (fill == '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/hcrm_back.sv =====
module hcrm_back import hcrm_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    q_empty,
  output logic                                    q_pop,
  input  logic [4+2*SAMPLE_BITS+2*COUNT_BITS-1:0] q_data,
  hcrm_out_if.source                              result
);

  localparam int SUM_BITS  = 2 * SAMPLE_BITS + COUNT_BITS;
  localparam int JOB_BITS  = 4 + SUM_BITS + COUNT_BITS;
  localparam int RAD_BITS  = SUM_BITS + (SUM_BITS % 2);
  localparam int ROOT_BITS = RAD_BITS / 2;
  localparam int STEP_BITS = $clog2(SUM_BITS);

  back_state_t            state, state_next;
  logic [STEP_BITS-1:0]   step;
  logic                   last_div, last_sqrt;

  logic [1:0]             tag;
  logic [1:0]             status;
  logic [SAMPLE_BITS-1:0] rms;

  // Restoring divider: dq shifts the dividend out and the quotient in.
  logic [SUM_BITS-1:0]    dq, dq_step;
  logic [COUNT_BITS-1:0]  rem, rem_step, divisor;
  logic [COUNT_BITS:0]    trial, diff;
  logic                   fits;

  // Digit-by-digit square root, one root bit per cycle.
  logic [RAD_BITS-1:0]    rad;
  logic [ROOT_BITS:0]     srem, srem_step;
  logic [ROOT_BITS-1:0]   root, root_step;
  logic [ROOT_BITS+2:0]   sacc, stest, sdiff;
  logic                   sfits;
  logic [SAMPLE_BITS-1:0] root_clamped;

  logic [1:0]             job_tag, job_status;
  logic [SUM_BITS-1:0]    job_sum;
  logic [COUNT_BITS-1:0]  job_count;

  assign job_tag    = q_data[JOB_BITS-1 -: 2];
  assign job_status = q_data[JOB_BITS-3 -: 2];
  assign job_sum    = q_data[COUNT_BITS +: SUM_BITS];
  assign job_count  = q_data[COUNT_BITS-1:0];

  assign trial    = {rem, dq[SUM_BITS-1]};
  assign fits     = (trial >= {1'b0, divisor});
  assign diff     = trial - {1'b0, divisor};
  assign rem_step = fits ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
  assign dq_step  = {dq[SUM_BITS-2:0], fits};

  assign sacc      = {srem, rad[RAD_BITS-1 -: 2]};
  assign stest     = {1'b0, root, 2'b01};
  assign sfits     = (sacc >= stest);
  assign sdiff     = sacc - stest;
  assign srem_step = sfits ? sdiff[ROOT_BITS:0] : sacc[ROOT_BITS:0];
  assign root_step = {root[ROOT_BITS-2:0], sfits};

  assign root_clamped = (root_step > ROOT_BITS'({SAMPLE_BITS{1'b1}})) ? '1
                                                                      : root_step[SAMPLE_BITS-1:0];

  assign last_div  = (step == STEP_BITS'(SUM_BITS - 1));
  assign last_sqrt = (step == STEP_BITS'(ROOT_BITS - 1));

  always_comb begin
    state_next   = state;
    q_pop        = 1'b0;
    result.valid = 1'b0;
    case (state)
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          state_next = (job_status == ST_OK) ? BK_DIV : BK_OUT;
        end
      end
      BK_DIV: begin
        if (last_div) begin
          state_next = BK_SQRT;
        end
      end
      BK_SQRT: begin
        if (last_sqrt) begin
          state_next = BK_OUT;
        end
      end
      BK_OUT: begin
        result.valid = 1'b1;
        if (result.ready) begin
          state_next = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else if (state == BK_IDLE || (state == BK_DIV && last_div) ||
                 (state == BK_SQRT && last_sqrt)) begin
      step <= '0;
    end else if (state == BK_DIV || state == BK_SQRT) begin
      step <= step + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      BK_IDLE: begin
        if (q_pop) begin
          tag     <= job_tag;
          status  <= job_status;
          rms     <= '0;
          dq      <= job_sum;
          divisor <= job_count;
          rem     <= '0;
        end
      end
      BK_DIV: begin
        dq  <= dq_step;
        rem <= rem_step;
        if (last_div) begin
          rad  <= RAD_BITS'(dq_step);
          srem <= '0;
          root <= '0;
        end
      end
      BK_SQRT: begin
        rad  <= {rad[RAD_BITS-3:0], 2'b00};
        srem <= srem_step;
        root <= root_step;
        if (last_sqrt) begin
          rms <= root_clamped;
        end
      end
      default: begin
      end
    endcase
  end

  assign result.tag    = tag;
  assign result.status = status;
  assign result.rms    = rms;

endmodule

// ===== rtl/half_cycle_rms_meter_core.sv =====
// Half-cycle true RMS meter. Items on the item channel are commands: start (latch the channel
// tag and arm), ADC sample, or timer tick. After a start the meter waits for a zero sample,
// then for a nonzero one, then sums the squares of the samples up to and including the next
// zero and reports floor(sqrt(floor(sum / count))) with status ok; a phase that sees
// timeout_ticks ticks ends with a timeout status for that phase and an rms of zero. The front
// end takes one item per clock while its two-entry job queue has room; the back end then
// fetches each job and runs its one-bit-per-cycle divider and its one-bit-per-cycle square
// root, then holds the result beat until it is taken; a timeout result skips the divider and
// the root. The timeout register resets to 65535 and should be written only while the meter
// is idle. There is no clearing pass after reset.
`include "assert_macros.svh"

module half_cycle_rms_meter_core import hcrm_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  hcrm_in_if.sink    item,
  hcrm_cfg_if.sink   cfg,
  hcrm_out_if.source result
);

  // A job carries the tag, the status, the square sum and the sample count.
  localparam int JOB_BITS = 4 + 2 * SAMPLE_BITS + 2 * COUNT_BITS;

  logic [TICK_BITS-1:0] timeout_ticks;

  logic                q_push, q_pop, q_full, q_empty;
  logic [JOB_BITS-1:0] q_in, q_out;

  // The timeout register accepts a write beat in every cycle.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
    end else if (cfg.valid) begin
      timeout_ticks <= cfg.data;
    end
  end

  // The front end tracks the phase and the running totals and queues a job whenever a
  // measurement finishes or times out.
  hcrm_front #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .item          (item),
    .timeout_ticks (timeout_ticks),
    .q_push        (q_push),
    .q_data        (q_in),
    .q_full        (q_full)
  );

  // The queue lets the front end keep taking samples while the back end is busy.
  hcrm_queue #(
    .WIDTH (JOB_BITS),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  // The back end divides, takes the root and holds the result beat until it is taken.
  hcrm_back #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .q_data  (q_out),
    .result  (result)
  );

  // A job is never pushed into a full queue, so none is lost.
  `ASSERT_IMPLIES(a_no_overflow, clk, rst, q_push, !q_full, "job pushed into a full queue")
  // A job is only taken from a queue that holds one.
  `ASSERT_IMPLIES(a_no_underflow, clk, rst, q_pop, !q_empty, "job popped from an empty queue")
  // The back end is busy in the cycle after it takes a job.
  `ASSERT_NEXT(a_pop_spacing, clk, rst, q_pop, !q_pop, "back end took two jobs in a row")
  // A timeout result always reports an rms of zero.
  `ASSERT_IMPLIES(a_timeout_zero, clk, rst, result.valid && (result.status != ST_OK),
                  result.rms == '0, "timeout result with nonzero rms")

endmodule

// ===== test/rms_result_checker.sv =====
`timescale 1ns / 100ps

// Watches the item, register and result channels of the RMS meter, keeps its own copy of the
// meter's state, and compares every result beat with the oldest predicted result.
module rms_result_checker import hcrm_pkg::*; (
  input  logic clk,
  input  logic rst,
  hcrm_in_if   item_mon,
  hcrm_cfg_if  cfg_mon,
  hcrm_out_if  result_mon,
  output int   mismatch_count,
  output int   results_pending
);

  localparam int SB    = SAMPLE_BITS_DEF;
  localparam int CB    = COUNT_BITS_DEF;
  localparam int SUM_W = 2 * SB + CB;

  localparam logic [SUM_W-1:0] SUM_LIMIT   = {SUM_W{1'b1}};
  localparam logic [CB-1:0]    COUNT_LIMIT = {CB{1'b1}};
  localparam logic [SB-1:0]    RMS_LIMIT   = {SB{1'b1}};

  typedef struct packed {
    logic [1:0]    tag;
    status_t       status;
    logic [SB-1:0] rms;
  } rms_result_t;

  rms_result_t pending_rms_results[$];

  phase_t               meter_phase;
  logic [1:0]           tag_latch;
  logic [TICK_BITS-1:0] ticks_seen;
  logic [TICK_BITS-1:0] timeout_limit;
  logic [SUM_W-1:0]     square_acc;
  logic [CB-1:0]        count_acc;

  initial mismatch_count = 0;

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  // Bitwise floor square root; the mean never exceeds SUM_W bits.
  function automatic longint unsigned floor_root(input longint unsigned v);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = SUM_W / 2; b >= 0; b--) begin
      trial = root | (longint'(1) << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  task automatic accumulate_square(input logic [SB-1:0] s);
    logic [SUM_W-1:0] sq;
    sq = SUM_W'(s) * SUM_W'(s);
    if (square_acc > SUM_LIMIT - sq) square_acc = SUM_LIMIT;
    else square_acc = square_acc + sq;
    if (count_acc != COUNT_LIMIT) count_acc = count_acc + 1'b1;
  endtask

  task automatic push_result(input status_t st, input logic [SB-1:0] r);
    rms_result_t res;
    res.tag    = tag_latch;
    res.status = st;
    res.rms    = r;
    pending_rms_results.push_back(res);
    meter_phase = PH_IDLE;
  endtask

  task automatic predict_meter_item(input logic [1:0] cmd, input logic [1:0] ch,
                                    input logic [SB-1:0] s);
    longint unsigned mean;
    longint unsigned root;
    status_t         st;
    case (cmd)
      CMD_START: begin
        tag_latch   = ch;
        meter_phase = PH_ZERO;
        ticks_seen  = '0;
        square_acc  = '0;
        count_acc   = '0;
      end
      CMD_TICK: begin
        if (meter_phase != PH_IDLE) begin
          if (ticks_seen != {TICK_BITS{1'b1}}) ticks_seen = ticks_seen + 1'b1;
          if (ticks_seen >= timeout_limit) begin
            case (meter_phase)
              PH_ZERO: st = ST_TO_ZERO;
              PH_RISE: st = ST_TO_RISE;
              default: st = ST_TO_HALF;
            endcase
            push_result(st, '0);
          end
        end
      end
      CMD_SAMPLE: begin
        case (meter_phase)
          PH_ZERO: begin
            if (s == '0) begin
              meter_phase = PH_RISE;
              ticks_seen  = '0;
            end
          end
          PH_RISE: begin
            if (s != '0) begin
              square_acc = '0;
              count_acc  = '0;
              accumulate_square(s);
              meter_phase = PH_ACC;
              ticks_seen  = '0;
            end
          end
          PH_ACC: begin
            accumulate_square(s);
            if (s == '0) begin
              mean = longint'(square_acc) / longint'(count_acc);
              root = floor_root(mean);
              if (root > longint'(RMS_LIMIT)) root = longint'(RMS_LIMIT);
              push_result(ST_OK, SB'(root));
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  endtask

  task automatic check_result_beat();
    rms_result_t want;
    if (pending_rms_results.size() == 0) begin
      report_mismatch($sformatf("result beat tag=%0d status=%0d rms=%0d with none expected",
                                result_mon.tag, result_mon.status, result_mon.rms));
    end else begin
      want = pending_rms_results.pop_front();
      if (result_mon.tag !== want.tag)
        report_mismatch($sformatf("tag %0d, expected %0d", result_mon.tag, want.tag));
      if (result_mon.status !== want.status)
        report_mismatch($sformatf("status %0d, expected %0d", result_mon.status, want.status));
      if (result_mon.rms !== want.rms)
        report_mismatch($sformatf("rms %0d, expected %0d", result_mon.rms, want.rms));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      meter_phase   = PH_IDLE;
      tag_latch     = '0;
      ticks_seen    = '0;
      timeout_limit = TIMEOUT_RESET;
      square_acc    = '0;
      count_acc     = '0;
      pending_rms_results.delete();
      results_pending <= 0;
    end else begin
      // A result can never stem from an item accepted at the same edge.
      if (result_mon.valid && result_mon.ready) check_result_beat();
      if (cfg_mon.valid && cfg_mon.ready) timeout_limit = cfg_mon.data;
      if (item_mon.valid && item_mon.ready)
        predict_meter_item(item_mon.command, item_mon.channel, item_mon.sample);
      results_pending <= pending_rms_results.size();
    end
  end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

// Stimulus and verdict for the half-cycle RMS meter. The checker instance beside the block
// predicts and compares; this module only creates traffic on the item, register and result
// channels and decides the outcome from the checker's mismatch count.
module testbench;
  import hcrm_pkg::*;

  localparam int SB = SAMPLE_BITS_DEF;

  // Command code 3 has no meaning; the meter must ignore it.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // Generous bound on the whole run.
  localparam int CYCLE_LIMIT = 1_000_000;

  // Extra cycles granted after the last expected result, well beyond the back-end latency.
  localparam int SETTLE_CYCLES = 100;

  logic clk;
  logic rst;

  int tx_idle_pct;
  int rx_idle_pct;
  int tick_pct;
  int items_sent;
  int cycle_count;
  int mismatch_count;
  int results_pending;

  hcrm_in_if  #(.SAMPLE_BITS(SB)) item_ch();
  hcrm_out_if #(.SAMPLE_BITS(SB)) result_ch();
  hcrm_cfg_if                     cfg_ch();

  half_cycle_rms_meter_core #(
    .SAMPLE_BITS(SB),
    .COUNT_BITS (COUNT_BITS_DEF)
  ) dut (
    .clk   (clk),
    .rst   (rst),
    .item  (item_ch),
    .cfg   (cfg_ch),
    .result(result_ch)
  );

  rms_result_checker checker_inst (
    .clk            (clk),
    .rst            (rst),
    .item_mon       (item_ch),
    .cfg_mon        (cfg_ch),
    .result_mon     (result_ch),
    .mismatch_count (mismatch_count),
    .results_pending(results_pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // The watchdog counts every clock; reaching the limit means the meter hung somewhere.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // The result receiver stalls at random with the current idle percentage.
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Offers one item beat, possibly after a random gap, and returns at the edge that accepts
  // it. Valid is left high so that a following beat continues without a bubble.
  task automatic send_item(input logic [1:0] cmd, input logic [1:0] ch,
                           input logic [SB-1:0] s);
    while ($urandom_range(99) < tx_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid   <= 1'b1;
    item_ch.command <= cmd;
    item_ch.channel <= ch;
    item_ch.sample  <= s;
    do @(posedge clk); while (item_ch.ready !== 1'b1);
    if (cmd != CMD_UNUSED) items_sent++;
  endtask

  // Same as send_item, but timer ticks may be slipped in ahead of the beat.
  task automatic send_with_ticks(input logic [1:0] cmd, input logic [1:0] ch,
                                 input logic [SB-1:0] s);
    while ($urandom_range(99) < tick_pct)
      send_item(CMD_TICK, 2'($urandom_range(3)), SB'($urandom));
    send_item(cmd, ch, s);
  endtask

  // Lowers valid and holds off until every predicted result has been seen on the result side.
  task automatic wait_for_results();
    item_ch.valid <= 1'b0;
    do @(posedge clk); while (results_pending != 0);
  endtask

  // Brings the meter back to idle before a register write. From any armed phase the beats
  // zero, one, zero finish a half cycle; while idle they are ignored. Afterwards the meter
  // gets extra cycles so that the back end is surely empty.
  task automatic settle_meter();
    send_item(CMD_SAMPLE, 2'd0, '0);
    send_item(CMD_SAMPLE, 2'd0, SB'(1));
    send_item(CMD_SAMPLE, 2'd0, '0);
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [TICK_BITS-1:0] ticks);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= ticks;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    cfg_ch.valid <= 1'b0;
  endtask

  // Nonzero samples lean toward the full-scale value and toward tiny values, where rounding
  // of the root is most delicate.
  function automatic logic [SB-1:0] pick_nonzero_sample();
    case ($urandom_range(3))
      0:       return {SB{1'b1}};
      1:       return SB'($urandom_range(15, 1));
      default: return SB'($urandom_range((1 << SB) - 1, 1));
    endcase
  endfunction

  // One well-formed measurement with random content: start, some nonzero noise while the
  // meter waits for zero, one or more zeros, a rising run of samples, and usually the closing
  // zero. Leaving the zero out makes the next start drop the measurement silently.
  task automatic run_half_cycle();
    int n;
    send_with_ticks(CMD_START, 2'($urandom_range(3)), SB'($urandom));
    n = $urandom_range(3);
    repeat (n) send_with_ticks(CMD_SAMPLE, 2'($urandom_range(3)), pick_nonzero_sample());
    n = $urandom_range(3, 1);
    repeat (n) send_with_ticks(CMD_SAMPLE, 2'($urandom_range(3)), '0);
    n = $urandom_range(16, 1);
    repeat (n) send_with_ticks(CMD_SAMPLE, 2'($urandom_range(3)), pick_nonzero_sample());
    if ($urandom_range(9) != 0) send_with_ticks(CMD_SAMPLE, 2'($urandom_range(3)), '0);
  endtask

  // Unstructured beats of any command, including the unused code and idle traffic.
  task automatic send_noise();
    int n;
    n = $urandom_range(4, 1);
    repeat (n) begin
      send_item(2'($urandom_range(3)), 2'($urandom_range(3)),
                ($urandom_range(9) < 3) ? '0 : SB'($urandom));
    end
  endtask

  task automatic run_random_segment(input logic [TICK_BITS-1:0] ticks, input int tx_pct,
                                    input int rx_pct, input int tk_pct, input int target);
    settle_meter();
    write_timeout(ticks);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    tick_pct    = tk_pct;
    items_sent  = 0;
    while (items_sent < target) begin
      if ($urandom_range(9) < 8) run_half_cycle();
      else send_noise();
      if ($urandom_range(49) == 0) wait_for_results();
    end
  endtask

  initial begin
    rst             = 1'b1;
    tx_idle_pct     = 20;
    rx_idle_pct     = 53;
    tick_pct        = 0;
    items_sent      = 0;
    item_ch.valid   <= 1'b0;
    item_ch.command <= CMD_START;
    item_ch.channel <= 2'd0;
    item_ch.sample  <= '0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.data     <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at the reset timeout. Ticks, samples and the unused code while idle must
    // all be ignored.
    send_item(CMD_TICK, 2'd0, '0);
    send_item(CMD_SAMPLE, 2'd0, {SB{1'b1}});
    send_item(CMD_UNUSED, 2'd3, {SB{1'b1}});

    // Voltage channel: nonzero before the first zero is skipped, repeated zeros keep the
    // meter waiting for the rise, and the unused code in the middle changes nothing.
    send_item(CMD_START, 2'd3, '0);
    send_item(CMD_SAMPLE, 2'd0, SB'(5));
    send_item(CMD_SAMPLE, 2'd0, '0);
    send_item(CMD_SAMPLE, 2'd0, '0);
    send_item(CMD_UNUSED, 2'd0, '0);
    send_item(CMD_SAMPLE, 2'd0, {SB{1'b1}});
    send_item(CMD_SAMPLE, 2'd0, {SB{1'b1}});
    send_item(CMD_SAMPLE, 2'd0, '0);

    // A second start while busy drops the first measurement; the smallest half cycle rounds
    // its root down to zero.
    send_item(CMD_START, 2'd0, '0);
    send_item(CMD_START, 2'd2, '0);
    send_item(CMD_SAMPLE, 2'd0, '0);
    send_item(CMD_SAMPLE, 2'd0, SB'(1));
    send_item(CMD_SAMPLE, 2'd0, '0);

    // Ticks far below the reset timeout do not end the measurement.
    send_item(CMD_START, 2'd1, '0);
    send_item(CMD_TICK, 2'd0, '0);
    send_item(CMD_SAMPLE, 2'd0, '0);
    send_item(CMD_SAMPLE, 2'd0, SB'(512));
    send_item(CMD_TICK, 2'd0, '0);
    send_item(CMD_SAMPLE, 2'd0, '0);

    // With a timeout of one tick, the first tick ends each phase with its own status.
    settle_meter();
    write_timeout(16'd1);
    send_item(CMD_START, 2'd1, '0);
    send_item(CMD_TICK, 2'd0, '0);
    send_item(CMD_START, 2'd2, '0);
    send_item(CMD_SAMPLE, 2'd0, '0);
    send_item(CMD_TICK, 2'd0, '0);
    send_item(CMD_START, 2'd3, '0);
    send_item(CMD_SAMPLE, 2'd0, '0);
    send_item(CMD_SAMPLE, 2'd0, SB'(7));
    send_item(CMD_TICK, 2'd0, '0);

    // Random part: sender idles 20 percent and receiver 53, then the other way round, then
    // no idling at all, each over two timeout settings.
    run_random_segment(16'd3, 20, 53, 8, 225);
    run_random_segment(16'd12, 20, 53, 15, 225);
    run_random_segment(16'($urandom_range(30, 2)), 53, 20, 15, 225);
    run_random_segment(16'd1, 53, 20, 4, 225);
    run_random_segment(16'hFFFF, 0, 0, 20, 225);
    run_random_segment(16'd8, 0, 0, 12, 225);

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/hcrm_pkg.sv
rtl/hcrm_ifs.sv
rtl/hcrm_front.sv
rtl/hcrm_queue.sv
rtl/hcrm_back.sv
rtl/half_cycle_rms_meter_core.sv
test/rms_result_checker.sv
test/testbench.sv
